[design/trook_pkg.sv]
`timescale 1ns / 1ps

package trook_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_UNIT_TICKS     = 2'd0,
    CFG_FRAME_REPEATS  = 2'd1,
    CFG_SYNC_GAP_UNITS = 2'd2
  } cfg_index_e;

  // Input word kinds carried in tuser.
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } command_e;

  // Tri-state symbol kinds.
  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_FLOAT = 2'd2
  } kind_e;

  localparam logic [7:0] UNIT_TICKS_RST     = 8'd5;
  localparam logic [3:0] FRAME_REPEATS_RST  = 4'd8;
  localparam logic [5:0] SYNC_GAP_UNITS_RST = 6'd31;

  // Symbol numbering: 0 is the sync, 1..12 are the data symbols.
  localparam logic [3:0] LAST_SYMBOL  = 4'd12;
  localparam logic [1:0] LAST_SEGMENT = 2'd3;
  localparam logic [3:0] HOUSE_SYMS   = 4'd5;
  localparam logic [3:0] DEVICE_END   = 4'd10;

  typedef struct packed {
    logic busy;
    logic line_level;
  } trook_result_t;

  // Kind of data symbol s (0..11) for the latched address and switch state.
  function automatic kind_e symbol_kind(input logic [3:0] s, input logic [4:0] house,
                                        input logic [4:0] device, input logic sw);
    logic [2:0] bit_idx;
    kind_e      kind;
    bit_idx = '0;
    if (s < HOUSE_SYMS) begin
      bit_idx = 3'(4'd4 - s);
      kind    = house[bit_idx] ? KIND_ONE : KIND_ZERO;
    end else if (s < DEVICE_END) begin
      bit_idx = 3'(4'd9 - s);
      kind    = device[bit_idx] ? KIND_ZERO : KIND_FLOAT;
    end else if (s == DEVICE_END) begin
      kind = sw ? KIND_ZERO : KIND_FLOAT;
    end else begin
      kind = sw ? KIND_FLOAT : KIND_ZERO;
    end
    return kind;
  endfunction

  // Length in units of one segment of a symbol.
  function automatic logic [1:0] segment_units(input kind_e kind, input logic [1:0] seg);
    logic [1:0] units;
    unique case (kind)
      KIND_ZERO:  units = seg[0] ? 2'd3 : 2'd1;
      KIND_ONE:   units = seg[0] ? 2'd1 : 2'd3;
      KIND_FLOAT: units = (seg == 2'd0 || seg == 2'd1) ? ((seg == 2'd0) ? 2'd1 : 2'd3)
                                                       : ((seg == 2'd2) ? 2'd3 : 2'd1);
      default:    units = 2'd1;
    endcase
    return units;
  endfunction

endpackage

[design/trook_core.sv]
`timescale 1ns / 1ps

module trook_core import trook_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i,
  input  logic          step_i,
  input  logic          command_i,
  input  logic [4:0]    house_i,
  input  logic [4:0]    device_i,
  input  logic          switch_i,
  output trook_result_t result_o
);

  logic [7:0] unit_ticks_q;
  logic [3:0] frame_repeats_q;
  logic [5:0] sync_gap_q;

  logic [4:0] house_q, house_d;
  logic [4:0] device_q, device_d;
  logic       switch_q, switch_d;
  logic [3:0] repeat_q, repeat_d;
  logic [3:0] symbol_q, symbol_d;
  logic [1:0] segment_q, segment_d;
  logic [5:0] units_q, units_d;
  logic [7:0] ticks_q, ticks_d;
  logic       active_q, active_d;
  logic       level_q, level_d;

  logic [7:0] eff_ticks;
  logic [3:0] eff_repeats;
  logic [5:0] eff_gap;
  logic [3:0] repeat_inc;
  logic       enter;

  // A zero register value behaves as one.
  assign eff_ticks   = (unit_ticks_q == '0) ? 8'd1 : unit_ticks_q;
  assign eff_repeats = (frame_repeats_q == '0) ? 4'd1 : frame_repeats_q;
  assign eff_gap     = (sync_gap_q == '0) ? 6'd1 : sync_gap_q;
  assign repeat_inc  = repeat_q + 4'd1;

  always_comb begin
    house_d   = house_q;
    device_d  = device_q;
    switch_d  = switch_q;
    repeat_d  = repeat_q;
    symbol_d  = symbol_q;
    segment_d = segment_q;
    units_d   = units_q;
    ticks_d   = ticks_q;
    active_d  = active_q;
    level_d   = level_q;
    enter     = 1'b0;

    if (command_i == CMD_START) begin
      if (!active_q) begin
        house_d   = house_i;
        device_d  = device_i;
        switch_d  = switch_i;
        active_d  = 1'b1;
        repeat_d  = '0;
        symbol_d  = '0;
        segment_d = '0;
        enter     = 1'b1;
      end
    end else if (active_q) begin
      priority if (ticks_q > 8'd1) begin
        ticks_d = ticks_q - 8'd1;
      end else if (units_q > 6'd1) begin
        units_d = units_q - 6'd1;
        ticks_d = eff_ticks;
      end else begin
        enter = 1'b1;
        priority if (symbol_q == '0) begin
          if (segment_q == '0) begin
            segment_d = 2'd1;
          end else begin
            symbol_d  = 4'd1;
            segment_d = '0;
          end
        end else if (segment_q < LAST_SEGMENT) begin
          segment_d = segment_q + 2'd1;
        end else if (symbol_q < LAST_SYMBOL) begin
          symbol_d  = symbol_q + 4'd1;
          segment_d = '0;
        end else begin
          repeat_d = repeat_inc;
          if (repeat_inc >= eff_repeats) begin
            enter     = 1'b0;
            active_d  = 1'b0;
            level_d   = 1'b0;
            repeat_d  = '0;
            symbol_d  = '0;
            segment_d = '0;
            units_d   = '0;
            ticks_d   = '0;
          end else begin
            symbol_d  = '0;
            segment_d = '0;
          end
        end
      end
    end

    // Load the counters for the segment just entered.
    if (enter) begin
      if (symbol_d == '0) begin
        units_d = (segment_d == '0) ? 6'd1 : eff_gap;
      end else begin
        units_d = 6'(segment_units(symbol_kind(symbol_d - 4'd1, house_q, device_q, switch_q),
                                   segment_d));
      end
      ticks_d = eff_ticks;
      level_d = ~segment_d[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q    <= UNIT_TICKS_RST;
      frame_repeats_q <= FRAME_REPEATS_RST;
      sync_gap_q      <= SYNC_GAP_UNITS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_UNIT_TICKS:     unit_ticks_q    <= cfg_data_i;
        CFG_FRAME_REPEATS:  frame_repeats_q <= cfg_data_i[3:0];
        CFG_SYNC_GAP_UNITS: sync_gap_q      <= cfg_data_i[5:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      house_q   <= '0;
      device_q  <= '0;
      switch_q  <= 1'b0;
      repeat_q  <= '0;
      symbol_q  <= '0;
      segment_q <= '0;
      units_q   <= '0;
      ticks_q   <= '0;
      active_q  <= 1'b0;
      level_q   <= 1'b0;
    end else if (step_i) begin
      house_q   <= house_d;
      device_q  <= device_d;
      switch_q  <= switch_d;
      repeat_q  <= repeat_d;
      symbol_q  <= symbol_d;
      segment_q <= segment_d;
      units_q   <= units_d;
      ticks_q   <= ticks_d;
      active_q  <= active_d;
      level_q   <= level_d;
    end
  end

  // The result reflects the state after this word has been applied.
  assign result_o.line_level = level_d;
  assign result_o.busy       = active_d;

endmodule

[design/tristate_ook_remote_encoder.sv]
`timescale 1ns / 1ps

// Tri-state on-off-keyed encoder for 433 MHz remote sockets.
// Input stream: every word is either a time tick (tuser low) or a start
// request (tuser high) carrying the house code, device code and on/off bit.
// A start while a transmission runs is ignored. Ticks while idle change nothing.
// Output stream: exactly one word per input word, holding the line level to
// drive for the coming tick and a busy flag. On the last tick of a
// transmission the word already shows the line low and busy clear.
// Timing: one input word per clock cycle while the output is not stalled;
// each result word is registered in the output stage. The frame sequencer
// updates its counters once per accepted word.
// Stalls: a two-entry output stage (result register plus skid register)
// separates the sides; s_axis_tready_o falls only when both are full, and
// drops no words. Reset returns the line to idle, empties both entries and
// restores the configuration registers (5 ticks per unit, 8 frames, a sync
// gap of 31 units). Configuration is written through cfg_we_i; the user
// must do so only while idle, as the block itself does not enforce it.

module tristate_ook_remote_encoder import trook_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [4:0] house_address, [9:5] device_address,
                                        // [10] switch_on, [15:11] zero
  input  logic        s_axis_tuser_i,   // [0] command
  // Output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [0] line_level, [1] busy_res, [7:2] zero
);

  trook_result_t result;
  trook_result_t out_data_q;
  trook_result_t skid_data_q;
  logic          out_valid_q;
  logic          skid_valid_q;
  logic          accept;
  logic          take;

  assign s_axis_tready_o = ~skid_valid_q;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign take            = out_valid_q & m_axis_tready_i;

  trook_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (accept),
    .command_i   (s_axis_tuser_i),
    .house_i     (s_axis_tdata_i[4:0]),
    .device_i    (s_axis_tdata_i[9:5]),
    .switch_i    (s_axis_tdata_i[10]),
    .result_o    (result)
  );

  // Output register with a skid entry behind it. While the skid entry is
  // full the input is held off, so a take and an accept never meet there.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_data_q   <= '0;
      skid_data_q  <= '0;
    end else if (take) begin
      if (skid_valid_q) begin
        out_data_q   <= skid_data_q;
        skid_valid_q <= 1'b0;
      end else if (accept) begin
        out_data_q <= result;
      end else begin
        out_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q) begin
        out_data_q  <= result;
        out_valid_q <= 1'b1;
      end else begin
        skid_data_q  <= result;
        skid_valid_q <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_data_q.busy, out_data_q.line_level};

endmodule
